### rtl/tdt_pkg.sv
// Shared definitions for the deduplicating triangle table.
// Holds the field widths, request codes and the controller/datapath link types.
// No dependencies.
package tdt_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_ENTRIES_DEF     = 1024;
    localparam int VERTEX_INDEX_BITS_DEF = 16;

    // Fixed port field widths.
    localparam int REQ_W       = 2;
    localparam int VERT_W      = 16;
    localparam int TRI_INDEX_W = 10;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;    // capture a new request and reset the scan
        logic scan;     // step the key store scan by one entry
        logic respond;  // form the result beat and update the table
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // hit found, all entries compared, or no scan needed
    } t_dp_status;

endpackage

### rtl/tdt_ctrl.sv
// Controller state machine for the deduplicating triangle table.
// Sequences request capture, the key store scan and the result beat.
// Depends on tdt_pkg.
module tdt_ctrl
    import tdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd.latch   = 1'b0;
        o_cmd.scan    = 1'b0;
        o_cmd.respond = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### rtl/tdt_datapath.sv
// Datapath of the deduplicating triangle table: key sorting, the key store
// memory with its sequential scan, the entry count and the result registers.
// Depends on tdt_pkg.
module tdt_datapath
    import tdt_pkg::*;
#(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [VERT_W-1:0]      i_vert_a,
    input  logic [VERT_W-1:0]      i_vert_b,
    input  logic [VERT_W-1:0]      i_vert_c,
    output t_dp_status             o_status,
    output logic                   o_done,
    output logic [TRI_INDEX_W-1:0] o_tri_index,
    output logic                   o_found,
    output logic                   o_full_res
);

    localparam int VB    = VERTEX_INDEX_BITS;
    localparam int KEY_W = 3 * VB;
    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CAPACITY = CW'(TABLE_ENTRIES);

    // Key store memory.
    logic [KEY_W-1:0] r_mem [0:TABLE_ENTRIES-1];
    logic [KEY_W-1:0] r_rd_data;

    logic [REQ_W-1:0] r_req;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_entry_count;
    logic [CW-1:0]    r_issue_addr;
    logic             r_cmp_pend;
    logic [AW-1:0]    r_cmp_addr;
    logic             r_hit;
    logic [AW-1:0]    r_hit_addr;

    logic                   r_done;
    logic [TRI_INDEX_W-1:0] r_tri_index;
    logic                   r_found;
    logic                   r_full_res;

    logic [VB-1:0]    lane0, lane1, lane2;
    logic [VB-1:0]    s0a, s1a, s1b, s2b, s0c, s1c;
    logic [KEY_W-1:0] sorted_key;
    logic             need_scan;
    logic             issue_ok;
    logic             hit_now;
    logic             table_full;
    logic             do_write;
    logic [AW-1:0]    n_idx;
    logic             n_found;
    logic             n_full;

    // Mask the vertex indices to VERTEX_INDEX_BITS and sort them ascending.
    always_comb begin
        lane0 = VB'(i_vert_a);
        lane1 = VB'(i_vert_b);
        lane2 = VB'(i_vert_c);
        s0a   = (lane0 > lane1) ? lane1 : lane0;
        s1a   = (lane0 > lane1) ? lane0 : lane1;
        s1b   = (s1a > lane2) ? lane2 : s1a;
        s2b   = (s1a > lane2) ? s1a : lane2;
        s0c   = (s0a > s1b) ? s1b : s0a;
        s1c   = (s0a > s1b) ? s0a : s1b;
        sorted_key = {s2b, s1c, s0c};
    end

    // Scan status: one entry is read per cycle and compared in the next.
    assign need_scan  = (r_req == REQ_INSERT) || (r_req == REQ_LOOKUP);
    assign issue_ok   = (r_issue_addr < r_entry_count);
    assign hit_now    = r_cmp_pend && (r_rd_data == r_key);
    assign table_full = (r_entry_count >= CAPACITY);
    assign o_status.scan_done = !need_scan || hit_now || (!r_cmp_pend && !issue_ok);

    // Result decode for the response cycle.
    always_comb begin
        n_idx    = '0;
        n_found  = 1'b0;
        n_full   = 1'b0;
        do_write = 1'b0;
        if (need_scan && r_hit) begin
            n_idx   = r_hit_addr;
            n_found = 1'b1;
        end else if (r_req == REQ_INSERT) begin
            if (table_full) begin
                n_full = 1'b1;
            end else begin
                n_idx    = r_entry_count[AW-1:0];
                do_write = 1'b1;
            end
        end
    end

    // Request capture, scan pointers and hit record.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req        <= i_req_type;
            r_key        <= sorted_key;
            r_issue_addr <= '0;
            r_hit        <= 1'b0;
        end else if (i_cmd.scan) begin
            if (issue_ok) begin
                r_issue_addr <= r_issue_addr + CW'(1);
                r_cmp_addr   <= r_issue_addr[AW-1:0];
            end
            if (hit_now && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_addr <= r_cmp_addr;
            end
        end
    end

    // Compare-pending flag is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_pend <= 1'b0;
        end else if (i_cmd.latch) begin
            r_cmp_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_pend <= issue_ok;
        end
    end

    // Memory read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && issue_ok) begin
            r_rd_data <= r_mem[r_issue_addr[AW-1:0]];
        end
    end

    // Memory write port: a new key goes to the next free entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.respond && do_write) begin
            r_mem[r_entry_count[AW-1:0]] <= r_key;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cmd.respond) begin
            if (r_req == REQ_CLEAR) begin
                r_entry_count <= '0;
            end else if (do_write) begin
                r_entry_count <= r_entry_count + CW'(1);
            end
        end
    end

    // Result beat: the strobe is high for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_tri_index <= TRI_INDEX_W'(n_idx);
            r_found     <= n_found;
            r_full_res  <= n_full;
        end
    end

    assign o_done      = r_done;
    assign o_tri_index = r_tri_index;
    assign o_found     = r_found;
    assign o_full_res  = r_full_res;

endmodule

### rtl/triangle_dedup_table.sv
// Deduplicating triangle table, top level. One request at a time, busy high meanwhile.
// The key store is scanned one entry per cycle, from entry 0 until a hit or the last stored
// entry; a clear or unknown request skips the scan. The next request can be accepted on
// the edge that takes the result beat, not before.
// Synchronous active-low reset empties the table; the receiver cannot stall the beat.
module triangle_dedup_table
    import tdt_pkg::*;
#(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [VERT_W-1:0]      i_vert_a,
    input  logic [VERT_W-1:0]      i_vert_b,
    input  logic [VERT_W-1:0]      i_vert_c,
    output logic                   o_done,
    output logic [TRI_INDEX_W-1:0] o_tri_index,
    output logic                   o_found,
    output logic                   o_full_res
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing.
    tdt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Key store and result generation.
    tdt_datapath #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .VERTEX_INDEX_BITS (VERTEX_INDEX_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_type  (i_req_type),
        .i_vert_a    (i_vert_a),
        .i_vert_b    (i_vert_b),
        .i_vert_c    (i_vert_c),
        .o_status    (status),
        .o_done      (o_done),
        .o_tri_index (o_tri_index),
        .o_found     (o_found),
        .o_full_res  (o_full_res)
    );

endmodule
